[sv/assert_macros.svh]
// Assertion macros shared by the gate opener RTL.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define ASSERT_IMPL(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

[sv/goc_pkg.sv]
// Types and constants for the gate opener controller.
// No dependencies.
package goc_pkg;
  typedef enum logic [3:0] {
    MODE_START = 4'd0, MODE_STOPPED = 4'd1, MODE_OPENING = 4'd2, MODE_CLOSING = 4'd3,
    MODE_OPEN = 4'd4, MODE_CLOSED = 4'd5, MODE_WAIT = 4'd6, MODE_PAUSE = 4'd7,
    MODE_ERROR = 4'd8, MODE_CAL = 4'd9
  } mode_t;
  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0, FAULT_BOTH = 2'd1, FAULT_TIME = 2'd2, FAULT_MAINT = 2'd3
  } fault_t;
  typedef enum logic [3:0] {
    OP_TICK = 4'd0, OP_OPEN = 4'd1, OP_CLOSE = 4'd2, OP_STOP = 4'd3, OP_RESET = 4'd4,
    OP_CAL_START = 4'd5, OP_CAL_END = 4'd6, OP_AUTO = 4'd7, OP_OTHER = 4'd8
  } op_t;
  typedef enum logic [2:0] {
    REG_AUTO_CLOSE = 3'd0, REG_TRAVEL = 3'd1, REG_PHOTO_WAIT = 3'd2,
    REG_REV_PAUSE = 3'd3, REG_AC_EN = 3'd4, REG_MAINT_EN = 3'd5
  } reg_idx_t;
  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_OUT} seq_t;
  localparam int unsigned TimeW = 32;
  localparam int unsigned MsPerSec = 1000;
  localparam int unsigned FullPct = 100;
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  // input and result words, first field in the top bits
  typedef struct packed {
    logic [3:0]  opcode;
    logic [31:0] time_ms;
    logic        limit_open_hit;
    logic        limit_closed_hit;
    logic        beam_blocked;
    logic        dip_auto_close_on;
    logic        dip_maintenance_on;
    logic        dip_reverse_on;
  } gate_in_t;

  typedef struct packed {
    logic [3:0] state_code;
    logic [1:0] error_code;
    logic [6:0] open_pct;
    logic       handled;
    logic       event_accepted;
    logic       drive_open;
    logic       drive_close;
  } gate_out_t;
endpackage

[sv/goc_if.sv]
// Valid/ready channel interface carrying a payload word.
// Depends on nothing; payload type is a parameter.
interface goc_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/gate_opener_controller.sv]
// Gate opener controller top level.
// Depends on goc_pkg, goc_if, goc_div, goc_fsm and assert_macros.svh.
//
// Usage: input words arrive on in_ch (opcode, time and sensor levels), one
// result word leaves on out_ch per input. Registers are written through
// cfg_we/cfg_idx/cfg_data while the block is idle.
// After an input word is accepted, the result is formed in steps: the
// elapsed-times-100 product is registered, the bit-serial divider is launched
// and scales it by the travel span, and then the mode logic is updated, whose
// registers present the result. The serial divider limits the rate: one item
// is in flight at a time and in_ch.ready is low until its result is taken, so
// no new word is accepted before the last one is through.
// A stalled receiver holds the result in the output register.
// Reset (rst, synchronous) returns the mode to starting, clears the fault,
// position and times, and loads register defaults: auto close 30 s,
// travel 20 s, photocell wait 5 s, reverse pause 2 s, auto close enabled,
// maintenance lock off. No clearing pass is needed.
`include "assert_macros.svh"
module gate_opener_controller import goc_pkg::*; (
  input logic        clk,
  input logic        rst,
  goc_if.sink        in_ch,
  goc_if.source      out_ch,
  input logic        cfg_we,
  input logic [2:0]  cfg_idx,
  input logic [15:0] cfg_data
);
  logic [15:0] ac_s, trav_s, pw_s, rp_s;
  logic        ac_en, mt_en;
  seq_t        st, st_next;
  logic [3:0]  op;
  logic [31:0] now, prod, span, quot, moved_from;
  logic [5:0]  sens;
  logic [14:0] res;
  div_ctl_t    dctl;
  logic        apply, dstart;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ac_s <= 16'd30; trav_s <= 16'd20; pw_s <= 16'd5; rp_s <= 16'd2;
      ac_en <= 1'b1; mt_en <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_AUTO_CLOSE: ac_s <= cfg_data;
        REG_TRAVEL:     trav_s <= cfg_data;
        REG_PHOTO_WAIT: pw_s <= cfg_data;
        REG_REV_PAUSE:  rp_s <= cfg_data;
        REG_AC_EN:      ac_en <= cfg_data[0];
        REG_MAINT_EN:   mt_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op <= in_ch.data.opcode; now <= in_ch.data.time_ms;
      sens <= {in_ch.data.limit_open_hit, in_ch.data.limit_closed_hit,
               in_ch.data.beam_blocked, in_ch.data.dip_auto_close_on,
               in_ch.data.dip_maintenance_on, in_ch.data.dip_reverse_on};
    end
    if (st == ST_MUL) begin
      prod <= (now - moved_from) * 32'(FullPct);
      span <= (trav_s == 16'd0) ? 32'd1 : 32'(trav_s) * 32'(MsPerSec);
    end
  end

  // sequencer
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: if (in_ch.valid) st_next = ST_MUL;
      ST_MUL:  st_next = ST_DIV;
      ST_DIV:  if (dctl.done) st_next = ST_OUT;
      ST_OUT:  if (out_ch.ready) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = (st == ST_IDLE);
    out_ch.valid = (st == ST_OUT);
    dstart       = 1'b0;
    apply        = (st == ST_DIV) && dctl.done;
  end

  logic dstart_r;
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE; dstart_r <= 1'b0;
    end else begin
      st <= st_next; dstart_r <= (st == ST_MUL);
    end
  end

  goc_div u_div (.clk, .rst, .start(dstart_r | dstart), .dividend(prod), .divisor(span),
                 .quotient(quot), .ctl(dctl));

  goc_fsm u_fsm (.clk, .rst, .apply, .op, .now, .sens, .delta(quot), .ac_s, .trav_s,
                 .pw_s, .rp_s, .ac_en, .mt_en, .moved_from, .res);

  // result word
  always_comb begin
    out_ch.data.state_code     = res[14:11];
    out_ch.data.error_code     = res[10:9];
    out_ch.data.open_pct       = res[8:2];
    out_ch.data.handled        = res[1];
    out_ch.data.event_accepted = res[0];
    out_ch.data.drive_open     = (res[14:11] == MODE_OPENING);
    out_ch.data.drive_close    = (res[14:11] == MODE_CLOSING);
  end

  `ASSERT_IMPL(a_one_side, clk, rst, 1'b1, !(in_ch.ready && out_ch.valid))
  `ASSERT_NEXT(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
  `ASSERT_IMPL(a_apply_div, clk, rst, apply, st == ST_DIV)
endmodule

[sv/goc_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on goc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module goc_div import goc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [TimeW-1:0] dividend,
  input  logic [TimeW-1:0] divisor,
  output logic [TimeW-1:0] quotient,
  output div_ctl_t         ctl
);
  logic [TimeW-1:0] rem;
  logic [TimeW-1:0] quo;
  logic [TimeW-1:0] dvs;
  logic [5:0]       count;
  logic             busy;
  logic             done;
  logic [TimeW:0]   trial;
  logic [TimeW:0]   shifted;

  // one trial subtraction a cycle
  assign shifted = {rem, quo[TimeW-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'(TimeW);
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[TimeW]) rem <= trial[TimeW-1:0];
      else rem <= shifted[TimeW-1:0];
      quo <= {quo[TimeW-2:0], ~trial[TimeW]};
    end
  end

  assign quotient = quo;
  assign ctl = '{start: start, busy: busy, done: done};

  `ASSERT_NEXT(a_div_done, clk, rst, busy && count == 6'd1, done && !busy)
  `ASSERT_IMPL(a_div_nostart, clk, rst, busy, !start)
  `ASSERT_NEXT(a_div_go, clk, rst, start, busy)
endmodule

[sv/goc_fsm.sv]
// Gate mode logic: applies one event given the position step.
// Depends on goc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module goc_fsm import goc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        apply,
  input  logic [3:0]  op,
  input  logic [31:0] now,
  input  logic [5:0]  sens,
  input  logic [31:0] delta,
  input  logic [15:0] ac_s,
  input  logic [15:0] trav_s,
  input  logic [15:0] pw_s,
  input  logic [15:0] rp_s,
  input  logic        ac_en,
  input  logic        mt_en,
  output logic [31:0] moved_from,
  output logic [14:0] res
);
  mode_t       mode, mode_next;
  fault_t      fault, fault_next;
  logic [6:0]  position, position_next, pos_trk;
  logic [31:0] entered, entered_next, moved_next, el;
  logic        revp, revp_next, acc, acc_next, ok;
  logic        lo, lc, bm, dac, dmt, drv, locked, acact, moving;
  logic [31:0] t_trav, t_ac, t_pw, t_rp;

  assign {lo, lc, bm, dac, dmt, drv} = sens;
  assign locked = dmt | mt_en;
  assign acact  = ac_en & dac & ~locked;
  assign moving = (mode == MODE_OPENING) || (mode == MODE_CLOSING);
  assign el     = now - entered;
  assign t_trav = 32'(trav_s) * 32'(MsPerSec);
  assign t_ac   = 32'(ac_s) * 32'(MsPerSec);
  assign t_pw   = 32'(pw_s) * 32'(MsPerSec);
  assign t_rp   = 32'(rp_s) * 32'(MsPerSec);

  // position after tracking
  always_comb begin
    pos_trk = position;
    if (mode == MODE_OPENING)
      pos_trk = (delta >= 32'(FullPct - position)) ? 7'(FullPct) : position + delta[6:0];
    else if (mode == MODE_CLOSING)
      pos_trk = (delta >= 32'(position)) ? 7'd0 : position - delta[6:0];
  end

  // next-state logic
  always_comb begin
    logic       cmd, cls, opn;
    logic [3:0] eop;
    mode_next = mode; fault_next = fault; position_next = pos_trk;
    entered_next = entered; revp_next = revp; acc_next = acc; ok = 1'b0;
    moved_next = moving ? now : moved_from;
    cmd = 1'b0; cls = 1'b0; opn = 1'b0;
    eop = (op > OP_OTHER) ? OP_OTHER : op;
    if (op == OP_TICK) begin
      if (lo && lc) begin
        fault_next = FAULT_BOTH; mode_next = MODE_ERROR; ok = 1'b1;
      end else if (mode == MODE_START) begin
        ok = 1'b1;
        if (lo) begin position_next = 7'(FullPct); mode_next = MODE_OPEN; end
        else if (lc) begin position_next = '0; mode_next = MODE_CLOSED; end
        else mode_next = MODE_STOPPED;
      end else if (mode == MODE_OPENING && lo) begin
        position_next = 7'(FullPct); mode_next = MODE_OPEN; ok = 1'b1;
      end else if (mode == MODE_OPENING && el >= t_trav) begin
        fault_next = FAULT_TIME; mode_next = MODE_ERROR; ok = 1'b1;
      end else if (mode == MODE_CLOSING && lc) begin
        position_next = '0; mode_next = MODE_CLOSED; ok = 1'b1;
      end else if (mode == MODE_CLOSING && bm) begin
        revp_next = drv; mode_next = MODE_PAUSE; ok = 1'b1;
      end else if (mode == MODE_CLOSING && el >= t_trav) begin
        fault_next = FAULT_TIME; mode_next = MODE_ERROR; ok = 1'b1;
      end else if (mode == MODE_OPEN && acact) begin
        mode_next = MODE_WAIT; ok = 1'b1;
      end else if (mode == MODE_WAIT && !acact) begin
        mode_next = MODE_OPEN; ok = 1'b1;
      end else if (mode == MODE_WAIT && el >= t_ac) begin
        cmd = 1'b1; eop = OP_AUTO;
      end else if (mode == MODE_PAUSE && revp && el >= t_rp) begin
        opn = 1'b1;
      end else if (mode == MODE_PAUSE && !revp && !bm && el >= t_pw) begin
        mode_next = MODE_STOPPED; ok = 1'b1;
      end
    end else cmd = 1'b1;
    // command handling (tracking already done; WAIT is not moving)
    if (cmd) begin
      acc_next = 1'b1; ok = 1'b1;
      case (eop)
        OP_STOP, OP_CAL_END: mode_next = MODE_STOPPED;
        OP_RESET: begin fault_next = FAULT_NONE; mode_next = MODE_STOPPED; end
        OP_CAL_START: mode_next = MODE_CAL;
        default: begin
          if (mode == MODE_ERROR) begin acc_next = 1'b0; ok = 1'b0; end
          else if (eop == OP_OPEN) opn = 1'b1;
          else if (eop == OP_CLOSE || eop == OP_AUTO) cls = 1'b1;
          else begin acc_next = 1'b0; ok = 1'b0; end
        end
      endcase
    end
    if (opn) begin
      ok = 1'b1;
      if (locked) begin fault_next = FAULT_MAINT; mode_next = MODE_ERROR; ok = 1'b0; end
      else if (lo) begin position_next = 7'(FullPct); mode_next = MODE_OPEN; end
      else begin fault_next = FAULT_NONE; mode_next = MODE_OPENING; end
    end
    if (cls) begin
      ok = 1'b1;
      if (locked) begin fault_next = FAULT_MAINT; mode_next = MODE_ERROR; ok = 1'b0; end
      else if (bm) begin mode_next = MODE_PAUSE; revp_next = 1'b0; ok = 1'b0; end
      else if (lc) begin position_next = '0; mode_next = MODE_CLOSED; end
      else begin fault_next = FAULT_NONE; mode_next = MODE_CLOSING; end
    end
    // entry time moves only when a mode is (re)entered; a refused event leaves it
    if (mode_next != mode || ok || opn || cls) entered_next = now;
    if ((opn || cls) && (mode_next == MODE_OPENING || mode_next == MODE_CLOSING))
      moved_next = now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_START; fault <= FAULT_NONE; position <= '0; entered <= '0;
      moved_from <= '0; revp <= 1'b0; acc <= 1'b0;
    end else if (apply) begin
      mode <= mode_next; fault <= fault_next; position <= position_next;
      entered <= entered_next; moved_from <= moved_next; revp <= revp_next;
      acc <= acc_next;
    end
  end

  logic ok_r;
  always_ff @(posedge clk) if (apply) ok_r <= ok;

  // result word
  assign res = {mode, fault, position, ok_r, acc};

  `ASSERT_IMPL(a_pos_range, clk, rst, 1'b1, position <= 7'(FullPct))
  `ASSERT_IMPL(a_err_fault, clk, rst, moving, fault == FAULT_NONE)
  `ASSERT_NEXT(a_hold, clk, rst, !apply, $stable(mode))
endmodule

[verif/gate_opener_controller_tb.sv]
// Self-checking testbench for the gate opener controller.
// Depends on goc_pkg, goc_if and gate_opener_controller; predicts each result word
// with an in-bench gate model, or takes it from a directed row, and checks it field by field.
module gate_opener_controller_tb;
  import goc_pkg::*;

  typedef struct {
    gate_in_t  word;
    bit        typed;
    gate_out_t want;
  } dir_row_t;

  localparam int Latency = 40;
  localparam int StallLimit = 5000;
  localparam int HoldCycles = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;

  goc_if #(.payload_t(gate_in_t))  in_ch ();
  goc_if #(.payload_t(gate_out_t)) out_ch ();

  gate_opener_controller uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Gate model state and registers
  int unsigned close_wait_s, travel_s, photo_wait_s, rev_pause_s;
  bit          ac_en, maint_en;
  mode_t       g_mode;
  fault_t      g_fault;
  int unsigned g_pos;
  logic [31:0] g_entered, g_moved;
  bit          g_rev_pending, g_accepted;
  bit          s_lo, s_lc, s_beam, s_dac, s_dmaint, s_drev;

  gate_out_t   results_due[$];
  dir_row_t    dir_rows[$];
  bit          failed = 1'b0;
  int          idle_tx = 0, idle_rx = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  logic [31:0] now_ms = 32'd0;

  function automatic bit elapsed_ok(logic [31:0] now, int unsigned secs);
    logic [31:0] span;
    span = secs * 1000;
    return (now - g_entered) >= span;
  endfunction

  function automatic bit ac_active();
    return ac_en && s_dac && !s_dmaint && !maint_en;
  endfunction

  function automatic void enter(mode_t m, logic [31:0] now);
    g_mode = m;
    g_entered = now;
    if (m == MODE_OPENING || m == MODE_CLOSING) g_moved = now;
  endfunction

  function automatic void trip(fault_t f, logic [31:0] now);
    g_fault = f;
    enter(MODE_ERROR, now);
  endfunction

  function automatic void follow_travel(logic [31:0] now);
    logic [31:0] span, prod, step;
    if (g_mode != MODE_OPENING && g_mode != MODE_CLOSING) return;
    span = travel_s * 1000;
    if (span == 0) span = 32'd1;
    prod = (now - g_moved) * 32'd100;
    step = prod / span;
    if (g_mode == MODE_OPENING) g_pos = (step >= 100 - g_pos) ? 100 : g_pos + step;
    else g_pos = (step >= g_pos) ? 0 : g_pos - step;
    g_moved = now;
  endfunction

  function automatic bit try_open(logic [31:0] now);
    if (s_dmaint || maint_en) begin
      trip(FAULT_MAINT, now);
      return 1'b0;
    end
    if (s_lo) begin
      g_pos = 100;
      enter(MODE_OPEN, now);
      return 1'b1;
    end
    g_fault = FAULT_NONE;
    enter(MODE_OPENING, now);
    return 1'b1;
  endfunction

  function automatic bit try_close(logic [31:0] now);
    if (s_dmaint || maint_en) begin
      trip(FAULT_MAINT, now);
      return 1'b0;
    end
    if (s_beam) begin
      enter(MODE_PAUSE, now);
      g_rev_pending = 1'b0;
      return 1'b0;
    end
    if (s_lc) begin
      g_pos = 0;
      enter(MODE_CLOSED, now);
      return 1'b1;
    end
    g_fault = FAULT_NONE;
    enter(MODE_CLOSING, now);
    return 1'b1;
  endfunction

  function automatic bit run_command(op_t op, logic [31:0] now);
    follow_travel(now);
    g_accepted = 1'b1;
    case (op)
      OP_STOP, OP_CAL_END: begin
        enter(MODE_STOPPED, now);
        return 1'b1;
      end
      OP_RESET: begin
        g_fault = FAULT_NONE;
        enter(MODE_STOPPED, now);
        return 1'b1;
      end
      OP_CAL_START: begin
        enter(MODE_CAL, now);
        return 1'b1;
      end
      default: ;
    endcase
    if (g_mode == MODE_ERROR) begin
      g_accepted = 1'b0;
      return 1'b0;
    end
    if (op == OP_OPEN) return try_open(now);
    if (op == OP_CLOSE || op == OP_AUTO) return try_close(now);
    g_accepted = 1'b0;
    return 1'b0;
  endfunction

  function automatic bit run_tick(logic [31:0] now);
    follow_travel(now);
    if (s_lo && s_lc) begin
      trip(FAULT_BOTH, now);
      return 1'b1;
    end
    if (g_mode == MODE_START) begin
      if (s_lo) begin
        g_pos = 100;
        enter(MODE_OPEN, now);
      end else if (s_lc) begin
        g_pos = 0;
        enter(MODE_CLOSED, now);
      end else begin
        enter(MODE_STOPPED, now);
      end
      return 1'b1;
    end
    if (g_mode == MODE_OPENING) begin
      if (s_lo) begin
        g_pos = 100;
        enter(MODE_OPEN, now);
        return 1'b1;
      end
      if (elapsed_ok(now, travel_s)) begin
        trip(FAULT_TIME, now);
        return 1'b1;
      end
    end
    if (g_mode == MODE_CLOSING) begin
      if (s_lc) begin
        g_pos = 0;
        enter(MODE_CLOSED, now);
        return 1'b1;
      end
      if (s_beam) begin
        g_rev_pending = s_drev;
        enter(MODE_PAUSE, now);
        return 1'b1;
      end
      if (elapsed_ok(now, travel_s)) begin
        trip(FAULT_TIME, now);
        return 1'b1;
      end
    end
    if (g_mode == MODE_OPEN && ac_active()) begin
      enter(MODE_WAIT, now);
      return 1'b1;
    end
    if (g_mode == MODE_WAIT) begin
      if (!ac_active()) begin
        enter(MODE_OPEN, now);
        return 1'b1;
      end
      if (elapsed_ok(now, close_wait_s)) return run_command(OP_AUTO, now);
    end
    if (g_mode == MODE_PAUSE) begin
      if (g_rev_pending && elapsed_ok(now, rev_pause_s)) return try_open(now);
      if (!g_rev_pending && !s_beam && elapsed_ok(now, photo_wait_s)) begin
        enter(MODE_STOPPED, now);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advance the gate model by one input word and return the result word
  function automatic gate_out_t gate_step(gate_in_t w);
    gate_out_t r;
    bit ok;
    op_t op;
    s_lo = w.limit_open_hit;
    s_lc = w.limit_closed_hit;
    s_beam = w.beam_blocked;
    s_dac = w.dip_auto_close_on;
    s_dmaint = w.dip_maintenance_on;
    s_drev = w.dip_reverse_on;
    if (w.opcode == OP_TICK) ok = run_tick(w.time_ms);
    else begin
      op = (w.opcode > OP_OTHER) ? OP_OTHER : op_t'(w.opcode);
      ok = run_command(op, w.time_ms);
    end
    r.state_code = g_mode;
    r.error_code = g_fault;
    r.open_pct = g_pos[6:0];
    r.handled = ok;
    r.event_accepted = g_accepted;
    r.drive_open = (g_mode == MODE_OPENING);
    r.drive_close = (g_mode == MODE_CLOSING);
    return r;
  endfunction

  // Register write: block side and model side together
  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_AUTO_CLOSE: close_wait_s = 32'(val);
      REG_TRAVEL:     travel_s = 32'(val);
      REG_PHOTO_WAIT: photo_wait_s = 32'(val);
      REG_REV_PAUSE:  rev_pause_s = 32'(val);
      REG_AC_EN:      ac_en = val[0];
      REG_MAINT_EN:   maint_en = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic settle();
    while (results_due.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  // Offer one word; valid stays high into the next send unless a gap is taken
  task automatic send_word(gate_in_t w, bit typed, gate_out_t want);
    gate_out_t pred;
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = gate_step(w);
    results_due.push_back(typed ? want : pred);
    if ($urandom_range(0, 99) < idle_tx) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic gate_in_t mk(op_t op, logic [31:0] t, logic [5:0] sens);
    gate_in_t w;
    w.opcode = op;
    w.time_ms = t;
    {w.limit_open_hit, w.limit_closed_hit, w.beam_blocked,
     w.dip_auto_close_on, w.dip_maintenance_on, w.dip_reverse_on} = sens;
    return w;
  endfunction

  function automatic void add_row(gate_in_t w, bit typed, gate_out_t want);
    dir_row_t r;
    r.word = w;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  function automatic gate_in_t rand_word();
    gate_in_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) now_ms += $urandom_range(0, 3000);
    else if (pick < 90) now_ms += $urandom_range(3000, 40000);
    else if (pick < 97) now_ms += $urandom_range(0, 200);
    else now_ms = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 50) w.opcode = OP_TICK;
    else if (pick < 65) w.opcode = OP_OPEN;
    else if (pick < 78) w.opcode = OP_CLOSE;
    else w.opcode = 4'($urandom_range(3, 15));
    w.time_ms = now_ms;
    w.limit_open_hit = ($urandom_range(0, 99) < 15);
    w.limit_closed_hit = ($urandom_range(0, 99) < 15);
    w.beam_blocked = ($urandom_range(0, 99) < 15);
    w.dip_auto_close_on = ($urandom_range(0, 99) < 70);
    w.dip_maintenance_on = ($urandom_range(0, 99) < 8);
    w.dip_reverse_on = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Result checker and receiver stalls
  always @(posedge clk) begin
    gate_out_t got, want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (results_due.size() == 0) begin
          $error("result word with nothing expected: %h", got);
          failed = 1'b1;
        end else begin
          want = results_due.pop_front();
          if (got.state_code !== want.state_code) begin
            $error("state_code exp %0d got %0d", want.state_code, got.state_code);
            failed = 1'b1;
          end
          if (got.error_code !== want.error_code) begin
            $error("error_code exp %0d got %0d", want.error_code, got.error_code);
            failed = 1'b1;
          end
          if (got.open_pct !== want.open_pct) begin
            $error("open_pct exp %0d got %0d", want.open_pct, got.open_pct);
            failed = 1'b1;
          end
          if (got.handled !== want.handled) begin
            $error("handled exp %0d got %0d", want.handled, got.handled);
            failed = 1'b1;
          end
          if (got.event_accepted !== want.event_accepted) begin
            $error("event_accepted exp %0d got %0d", want.event_accepted,
                   got.event_accepted);
            failed = 1'b1;
          end
          if (got.drive_open !== want.drive_open) begin
            $error("drive_open exp %0d got %0d", want.drive_open, got.drive_open);
            failed = 1'b1;
          end
          if (got.drive_close !== want.drive_close) begin
            $error("drive_close exp %0d got %0d", want.drive_close, got.drive_close);
            failed = 1'b1;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= idle_rx);
      end
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    gate_out_t none_typed;
    gate_in_t  w;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    none_typed = '0;

    // Defaults match the block's reset
    close_wait_s = 30; travel_s = 20; photo_wait_s = 5; rev_pause_s = 2;
    ac_en = 1'b1; maint_en = 1'b0;
    g_mode = MODE_START; g_fault = FAULT_NONE; g_pos = 0;
    g_entered = '0; g_moved = '0; g_rev_pending = 1'b0; g_accepted = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk: sensor bits are {lim_open, lim_closed, beam, dip_ac, dip_maint, dip_rev}
    add_row(mk(OP_TICK, 32'd0, 6'b000000), 1'b1,
            '{MODE_STOPPED, FAULT_NONE, 7'd0, 1'b1, 1'b0, 1'b0, 1'b0});
    add_row(mk(OP_OPEN, 32'd100, 6'b000000), 1'b0, none_typed);
    add_row(mk(OP_TICK, 32'd10100, 6'b000000), 1'b0, none_typed);
    add_row(mk(OP_TICK, 32'd20000, 6'b100000), 1'b1,
            '{MODE_OPEN, FAULT_NONE, 7'd100, 1'b1, 1'b1, 1'b0, 1'b0});
    add_row(mk(OP_TICK, 32'd20200, 6'b100100), 1'b0, none_typed);
    add_row(mk(OP_CLOSE, 32'd20300, 6'b001100), 1'b0, none_typed);
    add_row(mk(op_t'(4'd15), 32'd20400, 6'b000000), 1'b1,
            '{MODE_PAUSE, FAULT_NONE, 7'd100, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(mk(OP_TICK, 32'd20500, 6'b110000), 1'b1,
            '{MODE_ERROR, FAULT_BOTH, 7'd100, 1'b1, 1'b0, 1'b0, 1'b0});
    add_row(mk(OP_OPEN, 32'd20600, 6'b000000), 1'b0, none_typed);
    add_row(mk(OP_RESET, 32'd20700, 6'b000000), 1'b0, none_typed);
    add_row(mk(OP_OPEN, 32'd20800, 6'b000010), 1'b1,
            '{MODE_ERROR, FAULT_MAINT, 7'd100, 1'b0, 1'b1, 1'b0, 1'b0});
    add_row(mk(OP_RESET, 32'd20900, 6'b000000), 1'b0, none_typed);
    add_row(mk(OP_CLOSE, 32'd21000, 6'b000000), 1'b0, none_typed);
    add_row(mk(OP_TICK, 32'd25000, 6'b001001), 1'b0, none_typed);
    add_row(mk(OP_TICK, 32'd30000, 6'b000001), 1'b0, none_typed);
    add_row(mk(OP_TICK, 32'hFFFF_FF00, 6'b000000), 1'b0, none_typed);
    add_row(mk(OP_TICK, 32'h0000_0100, 6'b000000), 1'b0, none_typed);
    add_row(mk(OP_CAL_START, 32'h0000_0200, 6'b000000), 1'b0, none_typed);
    add_row(mk(OP_CAL_END, 32'h0000_0300, 6'b111111), 1'b0, none_typed);
    add_row(mk(OP_OTHER, 32'h0000_0400, 6'b000000), 1'b0, none_typed);
    add_row(mk(OP_AUTO, 32'h0000_0500, 6'b010000), 1'b0, none_typed);
    add_row(mk(OP_STOP, 32'hFFFF_FFFF, 6'b000000), 1'b0, none_typed);
    add_row(mk(op_t'(4'd14), 32'h8000_0000, 6'b000000), 1'b0, none_typed);
    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
    in_ch.valid <= 1'b0;
    settle();

    // Random phases under several register settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_TRAVEL, 16'd2); write_reg(REG_AUTO_CLOSE, 16'd3);
          write_reg(REG_PHOTO_WAIT, 16'd1); write_reg(REG_REV_PAUSE, 16'd1);
        end
        1: begin
          write_reg(REG_TRAVEL, 16'd0); write_reg(REG_AUTO_CLOSE, 16'd0);
          write_reg(REG_PHOTO_WAIT, 16'd0); write_reg(REG_REV_PAUSE, 16'd0);
        end
        2: begin
          write_reg(REG_TRAVEL, 16'hFFFF); write_reg(REG_AUTO_CLOSE, 16'hFFFF);
          write_reg(REG_PHOTO_WAIT, 16'hFFFF); write_reg(REG_REV_PAUSE, 16'hFFFF);
          write_reg(REG_MAINT_EN, 16'd1); write_reg(REG_AC_EN, 16'd0);
        end
        3: begin
          write_reg(REG_MAINT_EN, 16'd0); write_reg(REG_AC_EN, 16'd1);
          write_reg(REG_TRAVEL, 16'd5); write_reg(REG_AUTO_CLOSE, 16'd10);
          write_reg(REG_PHOTO_WAIT, 16'd2); write_reg(REG_REV_PAUSE, 16'd3);
        end
        4: begin
          write_reg(REG_AC_EN, 16'hFFFE); write_reg(REG_TRAVEL, 16'd1);
        end
        default: begin
          write_reg(REG_AC_EN, 16'd1); write_reg(REG_TRAVEL, 16'd20);
          write_reg(REG_AUTO_CLOSE, 16'd30);
        end
      endcase
      idle_tx = (ph % 3 == 0) ? 16 : (ph % 3 == 1) ? 57 : 0;
      idle_rx = (ph % 3 == 0) ? 57 : (ph % 3 == 1) ? 16 : 0;
      for (int n = 0; n < 130; n++) begin
        // long receiver hold-off while words keep being offered
        if (ph == 2 && n == 40) hold_left = HoldCycles;
        // sender drains everything before carrying on
        if (ph == 3 && n == 60) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (results_due.size() != 0) @(posedge clk);
        end
        w = rand_word();
        send_word(w, 1'b0, none_typed);
      end
      in_ch.valid <= 1'b0;
      settle();
    end

    if (!failed) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
